/* rtl/bfpa_pkg.sv */
// ----------------------------------------------------------------------------
// bfpa_pkg
// Shared types and codes for the best-fit fixed-partition allocator.
// ----------------------------------------------------------------------------
package bfpa_pkg;

  localparam int unsigned SizeW = 16;
  localparam int unsigned IdW   = 6;
  localparam int unsigned StW   = 4;
  localparam int unsigned OutIdxW = 4;

  typedef enum logic [1:0] {
    KIND_DEFINE = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_DELETE = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_e;

  typedef enum logic [StW-1:0] {
    ST_PART_OK    = 4'd0,
    ST_PART_REJ   = 4'd1,
    ST_PLACED     = 4'd2,
    ST_TOO_LARGE  = 4'd3,
    ST_EXISTS     = 4'd4,
    ST_NO_SPACE   = 4'd5,
    ST_INT_FRAG   = 4'd6,
    ST_EXT_FRAG   = 4'd7,
    ST_REMOVED    = 4'd8,
    ST_ABSENT     = 4'd9,
    ST_TABLE_FULL = 4'd10
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_SCAN,
    S_EXEC
  } state_e;

  typedef struct packed {
    logic load;
    logic scan_init;
    logic scan_step;
    logic exec;
  } bfpa_cmd_t;

  typedef struct packed {
    logic ins_scan;
    logic scan_done;
    logic out_free;
  } bfpa_stat_t;

endpackage

/* rtl/best_fit_fixed_partition_allocator_core.sv */
// Flow: an accepted word passes the look-up and execute states on its way to the
// result; an insert that reaches the best-fit scan steps through every defined
// partition (at least one) first. No new word is taken until the last is done;
// a result held by the receiver holds off the next word.
// Reset: async active low; tables empty, total memory 4096.
// ----------------------------------------------------------------------------
// best_fit_fixed_partition_allocator_core
// Best-fit fixed-partition allocator with stream in/out and one config reg.
// ----------------------------------------------------------------------------
module best_fit_fixed_partition_allocator_core import bfpa_pkg::*; #(
  parameter int unsigned NUM_PARTS = 16,
  parameter int unsigned NUM_PROCS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,  // proc_id[5:0], size[21:6], zero pad
  input  logic [1:0]  s_axis_tuser_i,  // kind[1:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,  // part_index[3:0], free_space[19:4], zero pad
  output logic [3:0]  m_axis_tuser_o   // status[3:0]
);

  bfpa_cmd_t  cmd;
  bfpa_stat_t stat;
  logic [OutIdxW-1:0] part_index;
  logic [SizeW-1:0]   free_space;

  bfpa_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  bfpa_dp #(
    .NUM_PARTS (NUM_PARTS),
    .NUM_PROCS (NUM_PROCS)
  ) u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i        (cmd),
    .stat_o       (stat),
    .kind_i       (s_axis_tuser_i),
    .proc_id_i    (s_axis_tdata_i[5:0]),
    .size_i       (s_axis_tdata_i[21:6]),
    .cfg_we_i,
    .cfg_wdata_i,
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .status_o     (m_axis_tuser_o),
    .part_index_o (part_index),
    .free_space_o (free_space)
  );

  assign m_axis_tdata_o = {4'b0, free_space, part_index};

endmodule

/* rtl/bfpa_ctrl.sv */
// ----------------------------------------------------------------------------
// bfpa_ctrl
// Sequencer: accept a word, look up the process table, scan partitions
// for inserts, then execute and hand the result to the output register.
// ----------------------------------------------------------------------------
module bfpa_ctrl import bfpa_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  bfpa_stat_t stat_i,
  output bfpa_cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_LOOK;
      end
      S_LOOK: begin
        state_d = stat_i.ins_scan ? S_SCAN : S_EXEC;
      end
      S_SCAN: begin
        if (stat_i.scan_done) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (stat_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      S_LOOK: cmd_o.scan_init = 1'b1;
      S_SCAN: cmd_o.scan_step = 1'b1;
      S_EXEC: cmd_o.exec = stat_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

/* rtl/bfpa_dp.sv */
// ----------------------------------------------------------------------------
// bfpa_dp
// Partition tables, process table memory, best-fit scan unit and the
// result register.
// ----------------------------------------------------------------------------
module bfpa_dp import bfpa_pkg::*; #(
  parameter int unsigned NUM_PARTS = 16,
  parameter int unsigned NUM_PROCS = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  bfpa_cmd_t        cmd_i,
  output bfpa_stat_t       stat_o,
  input  logic [1:0]       kind_i,
  input  logic [IdW-1:0]   proc_id_i,
  input  logic [SizeW-1:0] size_i,
  input  logic             cfg_we_i,
  input  logic [SizeW-1:0] cfg_wdata_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [StW-1:0]   status_o,
  output logic [OutIdxW-1:0] part_index_o,
  output logic [SizeW-1:0] free_space_o
);

  localparam int unsigned PW = $clog2(NUM_PARTS);
  localparam int unsigned CW = $clog2(NUM_PARTS + 1);
  localparam int unsigned QW = $clog2(NUM_PROCS);

  logic [SizeW-1:0] part_size_q [NUM_PARTS];
  logic [SizeW-1:0] part_occsz_q [NUM_PARTS];
  logic [NUM_PARTS-1:0] part_acc_q, part_occ_q;
  logic [CW-1:0]    part_cnt_q;

  logic [PW-1:0]    proc_mem [NUM_PROCS];
  logic [NUM_PROCS-1:0] proc_vld_q;
  logic [PW-1:0]    pp_rd_q;
  logic             pv_rd_q;

  logic [SizeW-1:0] total_q, unpart_q, used_q, largest_q, ptotal_q;
  kind_e            kind_q;
  logic [QW-1:0]    addr_q;
  logic [SizeW-1:0] size_q;
  logic             oor_q;

  logic [PW-1:0]    scan_q, best_idx_q;
  logic [SizeW:0]   best_q;
  logic             found_q, slack_q;

  logic             out_valid_q;
  logic [StW-1:0]   status_q;
  logic [OutIdxW-1:0] pidx_q;
  logic [SizeW-1:0] fs_q;

  logic [QW-1:0]    in_addr;
  logic             in_oor;
  logic [PW-1:0]    rd_idx;
  logic [SizeW-1:0] rd_size, rd_occsz, unused;
  logic             in_range, fit, slack_hit;
  logic [PW-1:0]    cnt_idx;

  assign in_addr  = QW'(proc_id_i);
  assign in_oor   = 32'(proc_id_i) >= NUM_PROCS;
  assign rd_idx   = (kind_q == KIND_DELETE) ? pp_rd_q : scan_q;
  assign rd_size  = part_size_q[rd_idx];
  assign rd_occsz = part_occsz_q[rd_idx];
  assign unused   = ptotal_q - used_q;
  assign cnt_idx  = PW'(part_cnt_q);
  assign in_range = CW'(scan_q) < part_cnt_q;
  assign fit = in_range && part_acc_q[scan_q] && !part_occ_q[scan_q] &&
               (size_q <= rd_size) && ({1'b0, rd_size} < best_q);
  assign slack_hit = in_range && part_occ_q[scan_q] && (rd_size >= rd_occsz) &&
                     ((rd_size - rd_occsz) >= size_q);

  assign stat_o.ins_scan  = (kind_q == KIND_INSERT) && !oor_q && (size_q <= largest_q) &&
                            !pv_rd_q && (size_q <= unused);
  assign stat_o.scan_done = (CW'(scan_q) + CW'(1)) >= part_cnt_q;
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign part_index_o = pidx_q;
  assign free_space_o = fs_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q  <= kind_e'(kind_i);
      addr_q  <= in_addr;
      size_q  <= size_i;
      oor_q   <= in_oor;
      pp_rd_q <= proc_mem[in_addr];
      pv_rd_q <= proc_vld_q[in_addr];
    end
    if (cmd_i.scan_init) begin
      scan_q <= '0;
      best_q <= {1'b1, {SizeW{1'b0}}};
      best_idx_q <= '0;
      found_q <= 1'b0;
      slack_q <= 1'b0;
    end
    if (cmd_i.scan_step) begin
      scan_q <= scan_q + PW'(1);
      if (fit) begin
        best_q     <= {1'b0, rd_size};
        best_idx_q <= scan_q;
        found_q    <= 1'b1;
      end
      if (slack_hit) slack_q <= 1'b1;
    end
    if (cmd_i.exec) begin
      case (kind_q)
        KIND_DEFINE: begin
          if (part_cnt_q < CW'(NUM_PARTS)) part_size_q[cnt_idx] <= size_q;
        end
        KIND_INSERT: begin
          if (stat_o.ins_scan && found_q) begin
            part_occsz_q[best_idx_q] <= size_q;
            proc_mem[addr_q] <= best_idx_q;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      part_acc_q  <= '0;
      part_occ_q  <= '0;
      part_cnt_q  <= '0;
      proc_vld_q  <= '0;
      total_q     <= 16'd4096;
      unpart_q    <= 16'd4096;
      used_q      <= '0;
      largest_q   <= '0;
      ptotal_q    <= '0;
      out_valid_q <= 1'b0;
      status_q    <= '0;
      pidx_q      <= '0;
      fs_q        <= '0;
    end else begin
      if (out_ready_i) out_valid_q <= 1'b0;
      if (cfg_we_i) begin
        total_q <= cfg_wdata_i;
        if (part_cnt_q == '0) unpart_q <= cfg_wdata_i;
      end
      if (cmd_i.exec) begin
        out_valid_q <= 1'b1;
        pidx_q      <= '0;
        fs_q        <= unused;
        case (kind_q)
          KIND_DEFINE: begin
            fs_q <= unpart_q;
            if (part_cnt_q >= CW'(NUM_PARTS)) begin
              status_q <= ST_TABLE_FULL;
            end else begin
              part_occ_q[cnt_idx] <= 1'b0;
              pidx_q <= OutIdxW'(cnt_idx);
              part_cnt_q <= part_cnt_q + CW'(1);
              if (size_q <= unpart_q) begin
                part_acc_q[cnt_idx] <= 1'b1;
                unpart_q <= unpart_q - size_q;
                fs_q     <= unpart_q - size_q;
                ptotal_q <= ptotal_q + size_q;
                if (size_q > largest_q) largest_q <= size_q;
                status_q <= ST_PART_OK;
              end else begin
                part_acc_q[cnt_idx] <= 1'b0;
                status_q <= ST_PART_REJ;
              end
            end
          end
          KIND_INSERT: begin
            if (oor_q) begin
              status_q <= ST_ABSENT;
            end else if (size_q > largest_q) begin
              status_q <= ST_TOO_LARGE;
            end else if (pv_rd_q) begin
              status_q <= ST_EXISTS;
              pidx_q   <= OutIdxW'(pp_rd_q);
            end else if (size_q > unused) begin
              status_q <= ST_NO_SPACE;
            end else if (found_q) begin
              part_occ_q[best_idx_q] <= 1'b1;
              proc_vld_q[addr_q] <= 1'b1;
              used_q   <= used_q + size_q;
              fs_q     <= unused - size_q;
              pidx_q   <= OutIdxW'(best_idx_q);
              status_q <= ST_PLACED;
            end else begin
              status_q <= slack_q ? ST_INT_FRAG : ST_EXT_FRAG;
            end
          end
          KIND_DELETE: begin
            if (oor_q || !pv_rd_q) begin
              status_q <= ST_ABSENT;
            end else begin
              part_occ_q[pp_rd_q] <= 1'b0;
              proc_vld_q[addr_q]  <= 1'b0;
              used_q   <= used_q - rd_occsz;
              fs_q     <= unused + rd_occsz;
              pidx_q   <= OutIdxW'(pp_rd_q);
              status_q <= ST_REMOVED;
            end
          end
          default: begin
            status_q   <= ST_PART_OK;
            part_acc_q <= '0;
            part_occ_q <= '0;
            proc_vld_q <= '0;
            part_cnt_q <= '0;
            unpart_q   <= total_q;
            used_q     <= '0;
            largest_q  <= '0;
            ptotal_q   <= '0;
          end
        endcase
      end
    end
  end

endmodule
